// ===== hw/rtl/nrle_pkg.sv =====
// nrle_pkg: shared types and constants for the nibble run-length decoder
// no dependencies; used by nibble_rle_decoder_top
package nrle_pkg;

  localparam int unsigned NIB_W  = 4;
  localparam int unsigned RUN_W  = 5;
  localparam int unsigned BYTE_W = 8;

  localparam logic [NIB_W-1:0] ESCAPE_NIBBLE = 4'hf;
  localparam logic [RUN_W-1:0] RUN_BIAS      = 5'd3;

  // sequencer state
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_NIB  = 2'b10
  } seq_state_t;

  // decoder phase
  typedef enum logic [2:0] {
    PH_LIT = 3'b001,
    PH_LEN = 3'b010,
    PH_REP = 3'b100
  } phase_t;

endpackage

// ===== hw/rtl/nibble_rle_decoder_top.sv =====
// nibble_rle_decoder_top: stream run-length decoder for 4-bit pixels with escape nibble
// depends on nrle_pkg
//
// One coded byte per input transfer is split into two nibbles, high nibble first, and
// each nibble steps a three-phase decoder: in the literal phase a nibble of 15 is an
// escape and any other nibble is one pixel; after an escape the next nibble sets a run
// of nibble + 3 pixels; the nibble after that is repeated for the whole run. Phase and
// run count carry across bytes. The byte sits in a shift register and leaves it one
// nibble at a time; a repeated nibble stays until its run is done. The nibble
// sequencer is the only datapath. The next byte is taken in the cycle its
// predecessor's last nibble retires. Output stalls hold the sequencer while the
// output register is full and the current nibble would emit. out_tlast marks the
// final pixel caused by one input byte; a byte that causes no pixel gives no output
// transfer.
module nibble_rle_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] coded_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] pixel, [7:4] zero
  output logic       out_tlast   // last_of_item
);

  localparam int unsigned NW = nrle_pkg::NIB_W;
  localparam int unsigned RW = nrle_pkg::RUN_W;

  // sequencer and decoder state
  nrle_pkg::seq_state_t state_r, state_nxt;
  nrle_pkg::phase_t     phase_r, phase_nxt;
  logic [RW-1:0]        run_len_r, run_len_nxt;
  logic [nrle_pkg::BYTE_W-1:0] byte_sr_r, byte_sr_nxt;  // nibble shift register
  logic                 nib_sel_r, nib_sel_nxt;         // 0 high nibble, 1 low nibble

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [NW-1:0] out_pix_r, out_pix_nxt;
  logic          out_last_r, out_last_nxt;

  logic [NW-1:0] nib;
  logic [NW-1:0] low_nib;
  logic          out_free;
  logic          emit;        // current nibble wants to emit a pixel this cycle
  logic          step;        // sequencer moves this cycle
  logic          nib_done;    // current nibble retires this cycle
  logic          low_emits;   // low nibble of this byte will emit
  nrle_pkg::phase_t phase_after;  // phase once the high nibble retires
  logic          in_xfer;
  logic          out_xfer;

  assign nib      = byte_sr_r[nrle_pkg::BYTE_W-1 -: NW];
  assign low_nib  = byte_sr_r[NW-1:0];
  assign out_xfer = out_valid_r && out_tready;
  assign out_free = !out_valid_r || out_tready;

  // look ahead: does the low nibble of the current byte produce any pixel
  always_comb begin
    unique case (phase_r)
      nrle_pkg::PH_LIT: begin
        phase_after = (nib == nrle_pkg::ESCAPE_NIBBLE) ? nrle_pkg::PH_LEN : nrle_pkg::PH_LIT;
      end
      nrle_pkg::PH_LEN: phase_after = nrle_pkg::PH_REP;
      nrle_pkg::PH_REP: phase_after = nrle_pkg::PH_LIT;
      default:          phase_after = nrle_pkg::PH_LIT;
    endcase
    low_emits = !nib_sel_r &&
                ((phase_after == nrle_pkg::PH_REP) ||
                 ((phase_after == nrle_pkg::PH_LIT) && (low_nib != nrle_pkg::ESCAPE_NIBBLE)));
  end

  // per-nibble decode
  always_comb begin
    emit        = 1'b0;
    nib_done    = 1'b0;
    phase_nxt   = phase_r;
    run_len_nxt = run_len_r;
    unique case (phase_r)
      nrle_pkg::PH_LEN: begin
        nib_done    = 1'b1;
        run_len_nxt = RW'(nib) + nrle_pkg::RUN_BIAS;
        phase_nxt   = nrle_pkg::PH_REP;
      end
      nrle_pkg::PH_REP: begin
        emit = 1'b1;
        if (run_len_r <= RW'(1)) begin
          nib_done  = 1'b1;
          phase_nxt = nrle_pkg::PH_LIT;
        end
        run_len_nxt = run_len_r - RW'(1);
      end
      default: begin
        // literal phase
        nib_done = 1'b1;
        if (nib == nrle_pkg::ESCAPE_NIBBLE) begin
          phase_nxt = nrle_pkg::PH_LEN;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
  end

  assign step      = (state_r == nrle_pkg::S_NIB) && (out_free || !emit);
  // next byte enters as soon as the low nibble retires
  assign in_tready = (state_r == nrle_pkg::S_IDLE) || (step && nib_done && nib_sel_r);
  assign in_xfer   = in_tvalid && in_tready;

  // sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    byte_sr_nxt   = byte_sr_r;
    nib_sel_nxt   = nib_sel_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    out_pix_nxt   = out_pix_r;
    out_last_nxt  = out_last_r;

    if (step) begin
      if (emit) begin
        out_valid_nxt = 1'b1;
        out_pix_nxt   = nib;
        // final pixel of the byte: run done and nothing left from the low nibble
        out_last_nxt  = nib_done && (nib_sel_r || !low_emits);
      end
      if (nib_done) begin
        if (nib_sel_r) begin
          state_nxt = nrle_pkg::S_IDLE;
        end else begin
          nib_sel_nxt = 1'b1;
          byte_sr_nxt = {byte_sr_r[NW-1:0], {NW{1'b0}}};
        end
      end
    end

    if (in_xfer) begin
      state_nxt   = nrle_pkg::S_NIB;
      byte_sr_nxt = in_tdata;
      nib_sel_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nrle_pkg::S_IDLE;
      phase_r     <= nrle_pkg::PH_LIT;
      run_len_r   <= '0;
      nib_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nib_sel_r   <= nib_sel_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) begin
        phase_r   <= phase_nxt;
        run_len_r <= run_len_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    byte_sr_r  <= byte_sr_nxt;
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8-NW){1'b0}}, out_pix_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // an accepted byte starts on its high nibble
  a_accept_starts_high: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (state_r == nrle_pkg::S_NIB) && !nib_sel_r)
    else $error("accepted byte did not start on high nibble");

  // repeat count stays within the legal run range
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nrle_pkg::S_NIB) && (phase_r == nrle_pkg::PH_REP) |->
      (run_len_r != '0) && (run_len_r <= RW'(18)))
    else $error("run count out of range in repeat phase");

  // a pixel that is not the end of its run is never flagged last
  a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == nrle_pkg::PH_REP) && (run_len_r > RW'(1)) |=>
      out_valid_r && !out_last_r)
    else $error("last flag raised inside a run");

  // no new byte while the high nibble is still pending
  a_no_accept_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nrle_pkg::S_NIB) && !nib_sel_r |-> !in_tready)
    else $error("input ready while high nibble pending");
`endif

endmodule
